// ===== rtl/core/bdr_pkg.sv =====
// shared types and constants for the batched datagram reorder block
package bdr_pkg;

  // fixed field and counter widths
  localparam int CNT_W  = 7;
  localparam int SEQ_W  = 6;
  localparam int GRP_W  = 6;
  localparam int DATA_W = 32;
  localparam int CFG_W  = 7;
  localparam int REG_W  = 1;

  // defaults for top level parameters
  localparam int CAPACITY_DEF      = 64;
  localparam int PAYLOAD_WIDTH_DEF = 32;

  // depth of the command queue between front and back
  localparam int QDEPTH = 2;

  // configuration register indexes
  typedef enum logic [REG_W-1:0] {
    REG_BATCH_SIZE    = 1'b0,
    REG_TOTAL_PACKETS = 1'b1
  } reg_e_t;

  // work handed from front to back
  typedef enum logic [1:0] {
    CMD_DROP,
    CMD_RUN,
    CMD_FLUSH
  } cmd_kind_t;

  // back end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_FLUSH
  } back_state_t;

  typedef struct packed {
    logic [SEQ_W-1:0]  seq_number;
    logic [DATA_W-1:0] payload_handle;
  } item_t;

  typedef struct packed {
    logic [GRP_W-1:0]  group_index;
    logic [SEQ_W-1:0]  out_seq;
    logic [DATA_W-1:0] out_payload;
    logic              last_in_group;
    logic              drop_flag;
  } result_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [GRP_W-1:0]  grp;
    logic [SEQ_W-1:0]  seq;
  } cmd_t;

endpackage

// ===== rtl/core/bdr_ram.sv =====
// generic single write port ram with registered read
module bdr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/bdr_fifo.sv =====
// short command queue between the front and back parts
module bdr_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  bdr_pkg::cmd_t din,
  input  logic          pop,
  output bdr_pkg::cmd_t dout,
  output logic          empty
);

  localparam int QD  = bdr_pkg::QDEPTH;
  localparam int PTW = $clog2(QD);
  localparam int CTW = $clog2(QD + 1);

  bdr_pkg::cmd_t  mem [QD];
  logic [PTW-1:0] wr_ptr;
  logic [PTW-1:0] rd_ptr;
  logic [CTW-1:0] count;
  logic           full;
  logic           do_push;
  logic           do_pop;

  assign empty   = (count == '0);
  assign full    = (count == CTW'(QD));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTW'(QD - 1)) ? '0 : wr_ptr + PTW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTW'(QD - 1)) ? '0 : rd_ptr + PTW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CTW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CTW'(1);
      end
    end
  end

endmodule

// ===== rtl/core/bdr_front.sv =====
// front part: config registers, arrival checks, counters and command issue
module bdr_front #(
  parameter int CAPACITY      = bdr_pkg::CAPACITY_DEF,
  parameter int PAYLOAD_WIDTH = bdr_pkg::PAYLOAD_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [bdr_pkg::REG_W-1:0]        cfg_index,
  input  logic [bdr_pkg::CFG_W-1:0]        cfg_data,
  input  logic                             accept,
  input  bdr_pkg::item_t                   item,
  input  logic [CAPACITY-1:0]              present_map,
  input  logic [$clog2(CAPACITY+1)-1:0]    next_release,
  output logic                             set_en,
  output logic [$clog2(CAPACITY)-1:0]      set_idx,
  output logic [PAYLOAD_WIDTH-1:0]         wr_data,
  output logic                             push,
  output bdr_pkg::cmd_t                    cmd
);

  localparam int IW   = $clog2(CAPACITY);
  localparam int CW   = bdr_pkg::CNT_W;
  localparam int GW   = bdr_pkg::GRP_W;
  localparam int DW   = bdr_pkg::DATA_W;
  localparam int KEEP = (PAYLOAD_WIDTH < DW) ? PAYLOAD_WIDTH : DW;

  logic [bdr_pkg::CFG_W-1:0] batch_size;
  logic [bdr_pkg::CFG_W-1:0] total_packets;
  logic [CW-1:0]             batch_count;
  logic [CW-1:0]             arrived_count;
  logic [GW-1:0]             groups_released;

  logic [CW-1:0] tot;
  logic [CW-1:0] seq_ext;
  logic [CW-1:0] nr_ext;
  logic [IW-1:0] seq_idx;
  logic [IW-1:0] nr_idx;
  logic [CW-1:0] batch_inc;
  logic [CW-1:0] arr_inc;
  logic          drop;
  logic          head_present;
  logic          batch_hit;
  logic          total_hit;

  // arrival classification
  always_comb begin
    tot       = (total_packets > CW'(CAPACITY)) ? CW'(CAPACITY) : total_packets;
    seq_ext   = CW'(item.seq_number);
    nr_ext    = CW'(next_release);
    seq_idx   = item.seq_number[IW-1:0];
    nr_idx    = next_release[IW-1:0];
    batch_inc = batch_count + CW'(1);
    arr_inc   = arrived_count + CW'(1);
    drop      = (arrived_count >= tot) || (seq_ext >= CW'(CAPACITY)) ||
                (seq_ext < nr_ext) || present_map[seq_idx];
    // head slot counts the datagram being stored now
    head_present = (nr_ext < CW'(CAPACITY)) &&
                   (present_map[nr_idx] || (seq_idx == nr_idx));
    batch_hit = (batch_inc == batch_size);
    total_hit = (arr_inc == tot);
  end

  // store request toward presence map and payload ram
  assign set_en  = accept && !drop;
  assign set_idx = seq_idx;
  assign wr_data = PAYLOAD_WIDTH'(item.payload_handle[KEEP-1:0]);

  // command to the back part
  always_comb begin
    push     = 1'b0;
    cmd.kind = bdr_pkg::CMD_DROP;
    cmd.grp  = groups_released;
    cmd.seq  = item.seq_number;
    if (accept) begin
      if (drop) begin
        push     = 1'b1;
        cmd.kind = bdr_pkg::CMD_DROP;
      end else if (batch_hit) begin
        push     = head_present;
        cmd.kind = bdr_pkg::CMD_RUN;
      end else if (total_hit) begin
        push     = 1'b1;
        cmd.kind = bdr_pkg::CMD_FLUSH;
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      batch_size    <= bdr_pkg::CFG_W'(1);
      total_packets <= bdr_pkg::CFG_W'(64);
    end else if (cfg_we) begin
      if (cfg_index == bdr_pkg::REG_BATCH_SIZE) begin
        batch_size <= cfg_data;
      end else if (cfg_index == bdr_pkg::REG_TOTAL_PACKETS) begin
        total_packets <= cfg_data;
      end
    end
  end

  // arrival, batch and group counters
  always_ff @(posedge clk) begin
    if (rst) begin
      batch_count     <= '0;
      arrived_count   <= '0;
      groups_released <= '0;
    end else if (accept && !drop) begin
      arrived_count <= arr_inc;
      batch_count   <= batch_hit ? '0 : batch_inc;
      if ((batch_hit && head_present) || (!batch_hit && total_hit)) begin
        groups_released <= groups_released + GW'(1);
      end
    end
  end

endmodule

// ===== rtl/core/bdr_back.sv =====
// back part: presence map, release walk and result register
module bdr_back #(
  parameter int CAPACITY      = bdr_pkg::CAPACITY_DEF,
  parameter int PAYLOAD_WIDTH = bdr_pkg::PAYLOAD_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_empty,
  input  bdr_pkg::cmd_t                  cmd,
  output logic                           pop,
  input  logic                           set_en,
  input  logic [$clog2(CAPACITY)-1:0]    set_idx,
  output logic [CAPACITY-1:0]            present_map,
  output logic [$clog2(CAPACITY+1)-1:0]  next_release,
  output logic                           rd_en,
  output logic [$clog2(CAPACITY)-1:0]    rd_addr,
  input  logic [PAYLOAD_WIDTH-1:0]       rd_data,
  output logic                           busy,
  output logic                           result_valid,
  output bdr_pkg::result_t               result
);

  localparam int IW   = $clog2(CAPACITY);
  localparam int NW   = $clog2(CAPACITY + 1);
  localparam int GW   = bdr_pkg::GRP_W;
  localparam int SW   = bdr_pkg::SEQ_W;
  localparam int DW   = bdr_pkg::DATA_W;
  localparam int KEEP = (PAYLOAD_WIDTH < DW) ? PAYLOAD_WIDTH : DW;

  bdr_pkg::back_state_t state;
  bdr_pkg::back_state_t state_next;
  logic [IW-1:0]        cursor;
  logic [IW-1:0]        cursor_next;
  logic [IW-1:0]        cursor_inc;
  logic [GW-1:0]        grp;
  logic [GW-1:0]        grp_next;
  logic                 at_end;
  logic                 last_run;
  logic                 last_flush;

  logic                 clr_en;
  logic                 nr_load;
  logic                 emit_en;
  logic                 emit_last;
  logic                 emit_drop;
  logic [SW-1:0]        emit_seq;
  logic [GW-1:0]        emit_grp;

  logic                 res_drop;
  logic                 res_last;
  logic [SW-1:0]        res_seq;
  logic [GW-1:0]        res_grp;

  // end of group detection for the two walks
  always_comb begin
    cursor_inc = cursor + IW'(1);
    at_end     = (cursor == IW'(CAPACITY - 1));
    last_run   = at_end || !present_map[cursor_inc];
    // flush clears ascending, so only bits at or above cursor remain
    last_flush = (present_map & ~(CAPACITY'(1) << cursor)) == '0;
  end

  // sequencer next state and outputs
  always_comb begin
    state_next  = state;
    cursor_next = cursor;
    grp_next    = grp;
    pop         = 1'b0;
    clr_en      = 1'b0;
    nr_load     = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = cursor;
    emit_en     = 1'b0;
    emit_last   = 1'b0;
    emit_drop   = 1'b0;
    emit_seq    = SW'(cursor);
    emit_grp    = grp;
    unique case (state)
      bdr_pkg::BK_IDLE: begin
        if (!q_empty) begin
          pop      = 1'b1;
          grp_next = cmd.grp;
          case (cmd.kind)
            bdr_pkg::CMD_DROP: begin
              emit_en   = 1'b1;
              emit_drop = 1'b1;
              emit_seq  = cmd.seq;
              emit_grp  = '0;
            end
            bdr_pkg::CMD_RUN: begin
              cursor_next = next_release[IW-1:0];
              state_next  = bdr_pkg::BK_RUN;
            end
            bdr_pkg::CMD_FLUSH: begin
              cursor_next = '0;
              state_next  = bdr_pkg::BK_FLUSH;
            end
            default: begin
              state_next = bdr_pkg::BK_IDLE;
            end
          endcase
        end
      end
      bdr_pkg::BK_RUN: begin
        rd_en       = 1'b1;
        clr_en      = 1'b1;
        nr_load     = 1'b1;
        emit_en     = 1'b1;
        emit_last   = last_run;
        cursor_next = cursor_inc;
        if (last_run) begin
          state_next = bdr_pkg::BK_IDLE;
        end
      end
      bdr_pkg::BK_FLUSH: begin
        if (present_map[cursor]) begin
          rd_en     = 1'b1;
          clr_en    = 1'b1;
          nr_load   = 1'b1;
          emit_en   = 1'b1;
          emit_last = last_flush;
        end
        cursor_next = cursor_inc;
        if ((present_map[cursor] && last_flush) || at_end) begin
          state_next = bdr_pkg::BK_IDLE;
        end
      end
      default: begin
        state_next = bdr_pkg::BK_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bdr_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // walk cursor and group number
  always_ff @(posedge clk) begin
    cursor <= cursor_next;
    grp    <= grp_next;
  end

  // presence map and release pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      present_map  <= '0;
      next_release <= '0;
    end else begin
      if (set_en) begin
        present_map[set_idx] <= 1'b1;
      end
      if (clr_en) begin
        present_map[cursor] <= 1'b0;
      end
      if (nr_load) begin
        next_release <= NW'(cursor) + NW'(1);
      end
    end
  end

  // result register, payload arrives from the ram read in the same cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= emit_en;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_en) begin
      res_drop <= emit_drop;
      res_last <= emit_last;
      res_seq  <= emit_seq;
      res_grp  <= emit_grp;
    end
  end

  // result beat
  always_comb begin
    result.group_index   = res_grp;
    result.out_seq       = res_seq;
    result.out_payload   = res_drop ? '0 : DW'(rd_data[KEEP-1:0]);
    result.last_in_group = res_last;
    result.drop_flag     = res_drop;
  end

  assign busy = (state != bdr_pkg::BK_IDLE);

endmodule

// ===== rtl/core/batched_datagram_reorder.sv =====
// top level of the batched datagram reorder block
//
// Datagrams enter on start/item; a beat is taken at a clock edge where start
// is high and busy is low. Each beat carries a sequence number and a payload
// handle. Results leave on result with result_valid high for one cycle each;
// the receiver always takes them.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 batch
// size, 1 total packets) at the clock edge; the user must write only while
// busy is low, the block itself does not enforce it. An arrival that
// releases nothing leaves busy low. A dropped arrival is queued; the back
// part pops it and registers its flagged result, holding busy high until
// then. A batch release walks the run from the next expected slot, one
// datagram per cycle; its command passes the queue and the back state
// register first, and busy stays high until the run ends. A final flush
// scans the presence map from slot 0, one slot per cycle, to the last held
// datagram or slot. The walk rate is set by the ram's single read port.
// Reset (rst, synchronous) clears the presence map and all counters and sets
// batch size 1 and total packets 64; no clearing pass is needed.
module batched_datagram_reorder #(
  parameter int CAPACITY      = bdr_pkg::CAPACITY_DEF,
  parameter int PAYLOAD_WIDTH = bdr_pkg::PAYLOAD_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  bdr_pkg::item_t            item,
  input  logic                      cfg_we,
  input  logic [bdr_pkg::REG_W-1:0] cfg_index,
  input  logic [bdr_pkg::CFG_W-1:0] cfg_data,
  output logic                      result_valid,
  output bdr_pkg::result_t          result
);

  localparam int IW = $clog2(CAPACITY);
  localparam int NW = $clog2(CAPACITY + 1);

  logic                     accept;
  logic [CAPACITY-1:0]      present_map;
  logic [NW-1:0]            next_release;
  logic                     set_en;
  logic [IW-1:0]            set_idx;
  logic [PAYLOAD_WIDTH-1:0] wr_data;
  logic                     push;
  bdr_pkg::cmd_t            cmd_in;
  bdr_pkg::cmd_t            cmd_out;
  logic                     pop;
  logic                     q_empty;
  logic                     rd_en;
  logic [IW-1:0]            rd_addr;
  logic [PAYLOAD_WIDTH-1:0] rd_data;
  logic                     back_busy;

  // input handshake
  assign accept = start && !busy;
  assign busy   = !q_empty || back_busy;

  // arrival checks and command issue
  bdr_front #(
    .CAPACITY      (CAPACITY),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .accept       (accept),
    .item         (item),
    .present_map  (present_map),
    .next_release (next_release),
    .set_en       (set_en),
    .set_idx      (set_idx),
    .wr_data      (wr_data),
    .push         (push),
    .cmd          (cmd_in)
  );

  // command queue
  bdr_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (cmd_in),
    .pop   (pop),
    .dout  (cmd_out),
    .empty (q_empty)
  );

  // held payloads, one slot per sequence number
  bdr_ram #(
    .WIDTH (PAYLOAD_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (set_en),
    .waddr (set_idx),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // release walks and result beats
  bdr_back #(
    .CAPACITY      (CAPACITY),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .cmd          (cmd_out),
    .pop          (pop),
    .set_en       (set_en),
    .set_idx      (set_idx),
    .present_map  (present_map),
    .next_release (next_release),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .busy         (back_busy),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule
